/* rtl/cfa_pkg.sv */
package cfa_pkg;

    // Build size of the frame map.
    localparam int MAX_FRAMES = 1024;
    localparam int IDX_W      = $clog2(MAX_FRAMES);

    // Field widths fixed by the interface.
    localparam int PAGE_W    = 20;
    localparam int CNT_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 20;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAGE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd1;

    // Request kinds.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_BADFREE  = 2'd2;
    localparam logic [1:0] ST_BADCOUNT = 2'd3;

    typedef struct packed {
        logic              req_type;
        logic [CNT_W-1:0]  count;
        logic              kernel;
        logic [PAGE_W-1:0] page_number;
    } t_req;

    typedef struct packed {
        logic [PAGE_W-1:0] page_number_out;
        logic [1:0]        status;
        logic [CNT_W-1:0]  free_frames;
    } t_res;

    // One frame map entry as stored in the memory.
    typedef struct packed {
        logic             used;
        logic             start;
        logic             kernel;
        logic [CNT_W-1:0] len;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_FREE_CHK,
        S_WIPE
    } t_state;

endpackage

/* rtl/cfa_ram.sv */
module cfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/contiguous_frame_allocator.sv */
// Channel   Direction  Handshake                  Payload
// request   in         start & !busy              i_req (t_req)
// result    out        o_res_valid, one cycle     o_res (t_res)
// config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// Allocate: a first-fit scan reads one map entry per cycle, then writes the
// run at one frame per cycle. Free: one read, then one write per frame of the
// run. Bad counts and out-of-range frees finish in the idle state without a
// map access; a free that names no run start costs one read more. After reset
// and after every write to a known configuration register a clearing pass
// over all MAX_FRAMES entries runs with busy high. The result strobe lasts
// one cycle and the receiver cannot hold it off.
module contiguous_frame_allocator (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  cfa_pkg::t_req           i_req,
    output logic                    o_res_valid,
    output cfa_pkg::t_res           o_res,
    input  logic                    i_cfg_we,
    input  logic [cfa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cfa_pkg::CFG_W-1:0]     i_cfg_data
);
    import cfa_pkg::*;

    t_state            r_state, n_state;
    logic [PAGE_W-1:0] r_base_page, n_base_page;
    logic [CNT_W-1:0]  r_frame_count, n_frame_count;
    logic [IDX_W-1:0]  r_addr, n_addr;
    logic [IDX_W-1:0]  r_rd, n_rd;
    logic              r_rd_on, n_rd_on;
    logic              r_chk_v, n_chk_v;
    logic [IDX_W-1:0]  r_chk_addr, n_chk_addr;
    logic [CNT_W-1:0]  r_run, n_run;
    logic [IDX_W-1:0]  r_start, n_start;
    logic [CNT_W-1:0]  r_left, n_left;
    t_req              r_req, n_req;
    logic [CNT_W-1:0]  r_free, n_free;
    t_res              r_res, n_res;
    logic              r_done, n_done;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    t_entry            ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry            w_rd;

    logic [CNT_W-1:0]  w_n;
    logic              w_accept;
    logic              w_bad_count;
    logic [PAGE_W-1:0] w_free_idx;
    logic              w_free_in_range;
    logic              w_last_rd;
    logic              w_chk_last;
    logic [CNT_W-1:0]  w_run_inc;
    logic              w_found;
    logic              w_clear_last;
    logic [CNT_W-1:0]  w_room;
    logic [CNT_W-1:0]  w_wipe_len;

    cfa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_FRAMES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign w_rd = t_entry'(ram_rdata);

    // Managed frame count, limited to the built depth.
    assign w_n = (32'(r_frame_count) > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) : r_frame_count;

    assign w_accept        = start && !busy;
    assign w_bad_count     = (i_req.count == '0) || (i_req.count > w_n);
    assign w_free_idx      = i_req.page_number - r_base_page;
    assign w_free_in_range = 32'(w_free_idx) < 32'(w_n);
    assign w_last_rd       = (32'(r_rd) + 32'd1) == 32'(w_n);
    assign w_chk_last      = (32'(r_chk_addr) + 32'd1) == 32'(w_n);
    assign w_run_inc       = r_run + CNT_W'(1);
    assign w_found         = !w_rd.used && (w_run_inc == r_req.count);
    assign w_clear_last    = r_addr == IDX_W'(MAX_FRAMES - 1);

    // Length of a released run, clipped to the managed frames.
    assign w_room     = w_n - CNT_W'(r_start);
    assign w_wipe_len = (w_rd.len > w_room) ? w_room : w_rd.len;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (w_clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.req_type == REQ_ALLOC) begin
                        if (!w_bad_count) n_state = S_SCAN;
                    end else if (w_free_in_range) begin
                        n_state = S_FREE_CHK;
                    end
                end
            end
            S_SCAN: begin
                if (r_chk_v) begin
                    if (w_found) n_state = S_FILL;
                    else if (w_chk_last) n_state = S_IDLE;
                end
            end
            S_FILL: begin
                if (r_left == CNT_W'(1)) n_state = S_IDLE;
            end
            S_FREE_CHK: begin
                if (w_rd.start && (w_wipe_len != '0)) n_state = S_WIPE;
                else n_state = S_IDLE;
            end
            S_WIPE: begin
                if (r_left == CNT_W'(1)) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
        // Only a write to a known register clears the map.
        if (i_cfg_we && ((i_cfg_idx == CFG_BASE_PAGE)
                         || (i_cfg_idx == CFG_FRAME_COUNT))) begin
            n_state = S_CLEAR;
        end
    end

    // Memory controls and datapath next values.
    always_comb begin
        n_base_page   = r_base_page;
        n_frame_count = r_frame_count;
        n_addr        = r_addr;
        n_rd          = r_rd;
        n_rd_on       = r_rd_on;
        n_chk_v       = r_chk_v;
        n_chk_addr    = r_chk_addr;
        n_run         = r_run;
        n_start       = r_start;
        n_left        = r_left;
        n_req         = r_req;
        n_free        = r_free;
        n_res         = r_res;
        n_done        = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = r_addr;
        ram_wdata     = '0;
        ram_raddr     = r_rd;

        case (r_state)
            // Sweep the map back to all free.
            S_CLEAR: begin
                ram_we = 1'b1;
                n_addr = r_addr + IDX_W'(1);
                if (w_clear_last) n_free = w_n;
            end

            // Take an item; bad counts and bad free pages finish at once.
            S_IDLE: begin
                ram_raddr = w_free_idx[IDX_W-1:0];
                if (w_accept) begin
                    n_req = i_req;
                    if (i_req.req_type == REQ_ALLOC) begin
                        if (w_bad_count) begin
                            n_res  = '{page_number_out: '0, status: ST_BADCOUNT,
                                       free_frames: r_free};
                            n_done = 1'b1;
                        end else begin
                            n_rd    = '0;
                            n_rd_on = 1'b1;
                            n_chk_v = 1'b0;
                            n_run   = '0;
                        end
                    end else if (w_free_in_range) begin
                        n_start = w_free_idx[IDX_W-1:0];
                    end else begin
                        n_res  = '{page_number_out: '0, status: ST_BADFREE,
                                   free_frames: r_free};
                        n_done = 1'b1;
                    end
                end
            end

            // First-fit scan: reads run one entry ahead of the check.
            S_SCAN: begin
                ram_raddr = r_rd;
                if (r_rd_on) begin
                    n_chk_v    = 1'b1;
                    n_chk_addr = r_rd;
                    if (w_last_rd) n_rd_on = 1'b0;
                    else n_rd = r_rd + IDX_W'(1);
                end else begin
                    n_chk_v = 1'b0;
                end
                if (r_chk_v) begin
                    n_run = w_rd.used ? '0 : w_run_inc;
                    if (!w_rd.used && (r_run == '0)) n_start = r_chk_addr;
                    if (w_found) begin
                        n_addr = (r_run == '0) ? r_chk_addr : r_start;
                        n_left = r_req.count;
                    end else if (w_chk_last) begin
                        n_res  = '{page_number_out: '0, status: ST_NOFIT,
                                   free_frames: r_free};
                        n_done = 1'b1;
                    end
                end
            end

            // Mark the found run used, one frame per cycle.
            S_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = '{used: 1'b1, start: (r_addr == r_start),
                              kernel: r_req.kernel, len: r_req.count};
                n_addr    = r_addr + IDX_W'(1);
                n_left    = r_left - CNT_W'(1);
                if (r_left == CNT_W'(1)) begin
                    n_free = r_free - r_req.count;
                    n_res  = '{page_number_out: r_base_page + PAGE_W'(r_start),
                               status: ST_OK, free_frames: r_free - r_req.count};
                    n_done = 1'b1;
                end
            end

            // The named entry must open a run.
            S_FREE_CHK: begin
                if (!w_rd.start) begin
                    n_res  = '{page_number_out: '0, status: ST_BADFREE,
                               free_frames: r_free};
                    n_done = 1'b1;
                end else if (w_wipe_len == '0) begin
                    n_res  = '{page_number_out: '0, status: ST_OK,
                               free_frames: r_free};
                    n_done = 1'b1;
                end else begin
                    n_addr = r_start;
                    n_left = w_wipe_len;
                    n_free = r_free + w_wipe_len;
                end
            end

            // Release the run, one frame per cycle.
            S_WIPE: begin
                ram_we = 1'b1;
                n_addr = r_addr + IDX_W'(1);
                n_left = r_left - CNT_W'(1);
                if (r_left == CNT_W'(1)) begin
                    n_res  = '{page_number_out: '0, status: ST_OK,
                               free_frames: r_free};
                    n_done = 1'b1;
                end
            end

            default: begin
                n_addr = '0;
            end
        endcase

        // A write to a known register restarts the clearing pass.
        if (i_cfg_we) begin
            if (i_cfg_idx == CFG_BASE_PAGE) begin
                n_base_page = i_cfg_data[PAGE_W-1:0];
                n_addr      = '0;
                n_done      = 1'b0;
            end else if (i_cfg_idx == CFG_FRAME_COUNT) begin
                n_frame_count = i_cfg_data[CNT_W-1:0];
                n_addr        = '0;
                n_done        = 1'b0;
            end
        end
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_base_page   <= '0;
            r_frame_count <= CNT_W'(1024);
            r_addr        <= '0;
            r_rd_on       <= 1'b0;
            r_chk_v       <= 1'b0;
            r_done        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_base_page   <= n_base_page;
            r_frame_count <= n_frame_count;
            r_addr        <= n_addr;
            r_rd_on       <= n_rd_on;
            r_chk_v       <= n_chk_v;
            r_done        <= n_done;
        end
        r_rd       <= n_rd;
        r_chk_addr <= n_chk_addr;
        r_run      <= n_run;
        r_start    <= n_start;
        r_left     <= n_left;
        r_req      <= n_req;
        r_free     <= n_free;
        r_res      <= n_res;
    end

    assign busy        = r_state != S_IDLE;
    assign o_res_valid = r_done;
    assign o_res       = r_res;

endmodule
